// ----- rtl/core/timestamped_id_table_aging_macros.svh -----
// Assertion macros shared by the table RTL.
`ifndef TIMESTAMPED_ID_TABLE_AGING_MACROS_SVH
`define TIMESTAMPED_ID_TABLE_AGING_MACROS_SVH

// Checked at every clock edge once reset is released.
`define TIA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TIA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/tia_pkg.sv -----
// Shared types and constants of the observed-robot table.
package tia_pkg;

    localparam int TABLE_SLOTS_DEF = 32;
    localparam int ID_W            = 8;
    localparam int TIME_W          = 32;
    localparam int FEAT_W          = 16;
    localparam int RANGE_W         = 16;
    localparam int OBS_W           = 16;
    localparam int COUNTS_W        = 3 * OBS_W;
    localparam int STATUS_W        = 3;
    localparam int OUT_CNT_W       = 6;

    typedef enum logic [STATUS_W-1:0] {
        STAT_UPDATED  = 3'd0,
        STAT_INSERTED = 3'd1,
        STAT_IGNORED  = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_TRIMMED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_UPDATE,
        OP_INSERT,
        OP_TRIM
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic apply;
        t_op  op;
    } t_cell_cmd;

    typedef struct packed {
        logic sel_hit;
        logic sel_free;
        logic newer;
        logic stale;
    } t_cell_stat;

endpackage

// ----- rtl/core/tia_cell.sv -----
// One table slot with its own key, age and freshness comparators.
module tia_cell
    import tia_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cap,
    input  logic [ID_W-1:0]     i_robot_id,
    input  logic [TIME_W-1:0]   i_sensed_time,
    input  logic [TIME_W-1:0]   i_threshold,
    input  logic                i_trim_en,
    input  t_cell_cmd           i_cmd,
    input  logic [ID_W-1:0]     i_wr_id,
    input  logic [TIME_W-1:0]   i_wr_time,
    input  logic [FEAT_W-1:0]   i_wr_feature,
    input  logic [RANGE_W-1:0]  i_wr_range,
    input  logic [COUNTS_W-1:0] i_wr_counts,
    input  logic                i_seen_hit,
    input  logic                i_seen_free,
    output logic                o_seen_hit,
    output logic                o_seen_free,
    output t_cell_stat          o_stat
);

    logic                r_valid;
    logic [ID_W-1:0]     r_robot;
    logic [TIME_W-1:0]   r_time;
    logic [FEAT_W-1:0]   r_feature;
    logic [RANGE_W-1:0]  r_range;
    logic [COUNTS_W-1:0] r_counts;
    logic                r_match;
    logic                r_newer;
    logic                r_stale;

    logic sel_hit;
    logic sel_free;
    logic do_write;
    logic do_insert;
    logic do_kill;

    // The lowest matching and the lowest free slot win along the row.
    assign sel_hit     = r_match && !i_seen_hit;
    assign sel_free    = !r_valid && !i_seen_free;
    assign o_seen_hit  = i_seen_hit || r_match;
    assign o_seen_free = i_seen_free || !r_valid;

    assign o_stat.sel_hit  = sel_hit;
    assign o_stat.sel_free = sel_free;
    assign o_stat.newer    = r_newer;
    assign o_stat.stale    = r_stale;

    assign do_insert = i_cmd.apply && (i_cmd.op == OP_INSERT) && sel_free;
    assign do_write  = do_insert || (i_cmd.apply && (i_cmd.op == OP_UPDATE) && sel_hit);
    assign do_kill   = i_cmd.apply && (i_cmd.op == OP_TRIM) && r_stale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (do_insert) begin
            r_valid <= 1'b1;
        end else if (do_kill) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_match <= r_valid && (r_robot == i_robot_id);
            r_newer <= i_sensed_time > r_time;
            r_stale <= r_valid && i_trim_en && (r_time < i_threshold);
        end
        if (do_insert) begin
            r_robot <= i_wr_id;
        end
        if (do_write) begin
            r_time    <= i_wr_time;
            r_feature <= i_wr_feature;
            r_range   <= i_wr_range;
            r_counts  <= i_wr_counts;
        end
    end

endmodule

// ----- rtl/core/timestamped_id_table_aging.sv -----
// Top level: a row of slot cells keyed by robot id, with timestamp aging.
// A request is compared in every slot cell as it is accepted, then applied in the
// apply state, where the priority chain along the row picks the slot and the result
// goes to the output register once that is free. No new request is taken until then.
// Reset clears all slot valid bits, the used-entry count and max_age at once.
`include "timestamped_id_table_aging_macros.svh"

module timestamped_id_table_aging
    import tia_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [TIME_W-1:0]    i_cfg_max_age,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_req_type,
    input  logic [ID_W-1:0]      i_robot_id,
    input  logic [TIME_W-1:0]    i_sensed_time,
    input  logic [FEAT_W-1:0]    i_feature_vector,
    input  logic [RANGE_W-1:0]   i_sense_range,
    input  logic [OBS_W-1:0]     i_obs_sensor_motor,
    input  logic [OBS_W-1:0]     i_obs_sensor_no_motor,
    input  logic [OBS_W-1:0]     i_obs_motor,
    input  logic [TIME_W-1:0]    i_now_time,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [OUT_CNT_W-1:0] o_removed_count,
    output logic [OUT_CNT_W-1:0] o_entries_used
);

    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    t_state r_state;
    t_state n_state;

    logic [TIME_W-1:0]    r_max_age;
    logic                 r_trim;
    logic [ID_W-1:0]      r_id;
    logic [TIME_W-1:0]    r_time;
    logic [FEAT_W-1:0]    r_feature;
    logic [RANGE_W-1:0]   r_range;
    logic [COUNTS_W-1:0]  r_counts;
    logic [CNT_W-1:0]     r_used;
    logic [CNT_W-1:0]     n_used;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [OUT_CNT_W-1:0] r_out_removed;
    logic [OUT_CNT_W-1:0] r_out_used;

    logic                 in_accept;
    logic                 out_free;
    logic                 apply_go;
    logic                 trim_en;
    logic [TIME_W-1:0]    threshold;

    logic [TABLE_SLOTS:0]   seen_hit;
    logic [TABLE_SLOTS:0]   seen_free;
    t_cell_stat             stat [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] hit_sel;
    logic [TABLE_SLOTS-1:0] free_sel;
    logic [TABLE_SLOTS-1:0] newer_v;
    logic [TABLE_SLOTS-1:0] stale_v;

    t_cell_cmd            cmd;
    t_op                  op;
    t_status              status;
    logic [CNT_W-1:0]     removed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= '0;
        end else if (i_cfg_valid) begin
            r_max_age <= i_cfg_max_age;
        end
    end

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign trim_en   = i_req_type && (i_now_time >= r_max_age);
    assign threshold = i_now_time - r_max_age;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_trim    <= i_req_type;
            r_id      <= i_robot_id;
            r_time    <= i_sensed_time;
            r_feature <= i_feature_vector;
            r_range   <= i_sense_range;
            r_counts  <= {i_obs_motor, i_obs_sensor_no_motor, i_obs_sensor_motor};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        apply_go   = (r_state == ST_APPLY) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign seen_hit[0]  = 1'b0;
    assign seen_free[0] = 1'b0;

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_slot
        tia_cell u_slot (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cap         (in_accept),
            .i_robot_id    (i_robot_id),
            .i_sensed_time (i_sensed_time),
            .i_threshold   (threshold),
            .i_trim_en     (trim_en),
            .i_cmd         (cmd),
            .i_wr_id       (r_id),
            .i_wr_time     (r_time),
            .i_wr_feature  (r_feature),
            .i_wr_range    (r_range),
            .i_wr_counts   (r_counts),
            .i_seen_hit    (seen_hit[g]),
            .i_seen_free   (seen_free[g]),
            .o_seen_hit    (seen_hit[g+1]),
            .o_seen_free   (seen_free[g+1]),
            .o_stat        (stat[g])
        );
        assign hit_sel[g]  = stat[g].sel_hit;
        assign free_sel[g] = stat[g].sel_free;
        assign newer_v[g]  = stat[g].newer;
        assign stale_v[g]  = stat[g].stale;
    end

    always_comb begin
        if (r_trim) begin
            op     = OP_TRIM;
            status = STAT_TRIMMED;
        end else if (seen_hit[TABLE_SLOTS]) begin
            if (|(hit_sel & newer_v)) begin
                op     = OP_UPDATE;
                status = STAT_UPDATED;
            end else begin
                op     = OP_NONE;
                status = STAT_IGNORED;
            end
        end else if (seen_free[TABLE_SLOTS]) begin
            op     = OP_INSERT;
            status = STAT_INSERTED;
        end else begin
            op     = OP_NONE;
            status = STAT_FULL;
        end
        cmd.apply = apply_go;
        cmd.op    = op;
    end

    // Stale flags are only set by a trim request, so this is zero for updates.
    always_comb begin
        removed = '0;
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            removed = removed + CNT_W'(stale_v[k]);
        end
    end

    assign n_used = r_used + CNT_W'(op == OP_INSERT) - removed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (apply_go) begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (apply_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply_go) begin
            r_out_status  <= status;
            r_out_removed <= OUT_CNT_W'(removed);
            r_out_used    <= OUT_CNT_W'(n_used);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_removed_count = r_out_removed;
    assign o_entries_used  = r_out_used;

    `TIA_ASSERT(a_one_hit_slot, (r_state == ST_APPLY) |-> $onehot0(hit_sel), "more than one slot selected as hit")
    `TIA_ASSERT(a_one_free_slot, (r_state == ST_APPLY) |-> $onehot0(free_sel), "more than one slot selected as free")
    `TIA_ASSERT(a_used_bound, r_used <= CNT_W'(TABLE_SLOTS), "used-entry count exceeds slot count")
    `TIA_ASSERT(a_insert_count, (apply_go && (op == OP_INSERT)) |=> (r_used == $past(r_used) + 1'b1), "insert did not add one entry")
    `TIA_ASSERT_ALWAYS(a_reset_out, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule
